>>> sv/gdl90_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// GDL90 frame receiver assertion macros
// Shared assertion forms for the deframer.
// ----------------------------------------------------------------------------
`ifndef GDL90_FRAME_RECEIVER_MACROS_SVH
`define GDL90_FRAME_RECEIVER_MACROS_SVH

// same-cycle implication, checked out of reset
`define GDL90FR_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gdl90fr assertion failed");

// next-cycle implication, checked out of reset
`define GDL90FR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gdl90fr assertion failed");

`endif

>>> sv/gdl90fr_pkg.sv
// ----------------------------------------------------------------------------
// gdl90fr_pkg
// Types, codes and the CRC-16 step for the GDL90 frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package gdl90fr_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 512;
  localparam int unsigned LEN_W               = 10;
  localparam int unsigned MIN_LEN_W           = 5;
  localparam int unsigned CFG_DATA_W          = 10;

  localparam logic [7:0] FLAG_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7D;
  localparam logic [7:0] STUFF_MASK = 8'h20;
  localparam logic [LEN_W-1:0] ABS_MIN_LEN = 10'd3;

  typedef enum logic [0:0] {
    CFG_MIN_LEN = 1'b0,
    CFG_MAX_LEN = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_IN_FRAME = 2'd1,
    MODE_UNSTUFF  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CRC_BAD  = 2'd1,
    ST_SHORT    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_END  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [MIN_LEN_W-1:0] min_len;
    logic [LEN_W-1:0]     max_len;
  } cfg_t;

  typedef struct packed {
    kind_t            item_kind;
    logic [7:0]       frame_byte;
    status_t          frame_status;
    logic [LEN_W-1:0] frame_length;
  } result_t;

  // CRC-CCITT (0x1021) table entry for one top byte
  function automatic logic [15:0] crc_tbl(input logic [7:0] top);
    logic [15:0] v;
    v = {top, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (v[15]) begin
        v = {v[14:0], 1'b0} ^ 16'h1021;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v;
  endfunction

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    return crc_tbl(crc[15:8]) ^ {crc[7:0], 8'h00} ^ {8'h00, b};
  endfunction

endpackage

`default_nettype wire

>>> sv/gdl90fr_if.sv
// ----------------------------------------------------------------------------
// gdl90fr channel interfaces
// Valid/ready channels for received bytes and for result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface gdl90fr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       batch_start;

  modport source (output valid, output rx_byte, output batch_start, input ready);
  modport sink   (input valid, input rx_byte, input batch_start, output ready);
endinterface

interface gdl90fr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           item_kind;
  logic [7:0]                     frame_byte;
  logic [1:0]                     frame_status;
  logic [gdl90fr_pkg::LEN_W-1:0]  frame_length;

  modport source (output valid, output item_kind, output frame_byte,
                  output frame_status, output frame_length, input ready);
  modport sink   (input valid, input item_kind, input frame_byte,
                  input frame_status, input frame_length, output ready);
endinterface

`default_nettype wire

>>> sv/gdl90fr_parser.sv
// ----------------------------------------------------------------------------
// gdl90fr_parser
// Flag detect, unstuffing, two-byte hold, running CRC and end status.
// ----------------------------------------------------------------------------
`default_nettype none

module gdl90fr_parser #(
  parameter int unsigned MAX_FRAME_BYTES = gdl90fr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                fire,
  input  wire logic [7:0]          rx_byte,
  input  wire logic                batch_start,
  input  wire gdl90fr_pkg::cfg_t   cfg,
  output logic                     res_valid,
  output gdl90fr_pkg::result_t     res
);

  localparam int unsigned CapBytes = (MAX_FRAME_BYTES > 1023) ? 1023 : MAX_FRAME_BYTES;
  localparam logic [gdl90fr_pkg::LEN_W-1:0] CapLen = gdl90fr_pkg::LEN_W'(CapBytes);

  gdl90fr_pkg::mode_t               mode_r, mode_nxt, mode_cur;
  logic [7:0]                       prev_r, prev_cur;
  logic [gdl90fr_pkg::LEN_W-1:0]    cnt_r, cnt_nxt;
  logic [15:0]                      crc_r, crc_nxt;
  logic [7:0]                       held0_r, held0_nxt, held1_r, held1_nxt;
  logic [gdl90fr_pkg::LEN_W-1:0]    eff_max;
  logic [7:0]                       data_b;
  logic                             is_open, is_esc, is_flag, ovf, short_frm, crc_ok;

  assign mode_cur = batch_start ? gdl90fr_pkg::MODE_IDLE : mode_r;
  assign prev_cur = batch_start ? gdl90fr_pkg::FLAG_BYTE : prev_r;

  always_comb begin
    if (cfg.max_len < gdl90fr_pkg::ABS_MIN_LEN) begin
      eff_max = gdl90fr_pkg::ABS_MIN_LEN;
    end else if (cfg.max_len > CapLen) begin
      eff_max = CapLen;
    end else begin
      eff_max = cfg.max_len;
    end
  end

  assign is_esc    = (rx_byte == gdl90fr_pkg::ESC_BYTE);
  assign is_flag   = (rx_byte == gdl90fr_pkg::FLAG_BYTE);
  assign is_open   = is_flag && (prev_cur == gdl90fr_pkg::FLAG_BYTE);
  assign ovf       = (cnt_r >= eff_max);
  assign short_frm = (cnt_r < {{(gdl90fr_pkg::LEN_W-gdl90fr_pkg::MIN_LEN_W){1'b0}}, cfg.min_len})
                     || (cnt_r < gdl90fr_pkg::ABS_MIN_LEN);
  assign crc_ok    = ({held1_r, held0_r} == crc_r);
  assign data_b    = (mode_cur == gdl90fr_pkg::MODE_UNSTUFF) ?
                     (rx_byte ^ gdl90fr_pkg::STUFF_MASK) : rx_byte;

  // next mode
  always_comb begin
    unique case (mode_cur)
      gdl90fr_pkg::MODE_IN_FRAME: begin
        if (is_esc) begin
          mode_nxt = gdl90fr_pkg::MODE_UNSTUFF;
        end else if (is_flag || ovf) begin
          mode_nxt = gdl90fr_pkg::MODE_IDLE;
        end else begin
          mode_nxt = gdl90fr_pkg::MODE_IN_FRAME;
        end
      end
      gdl90fr_pkg::MODE_UNSTUFF: begin
        mode_nxt = ovf ? gdl90fr_pkg::MODE_IDLE : gdl90fr_pkg::MODE_IN_FRAME;
      end
      default: begin
        mode_nxt = is_open ? gdl90fr_pkg::MODE_IN_FRAME : gdl90fr_pkg::MODE_IDLE;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    logic take;
    take      = 1'b0;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    held0_nxt = held0_r;
    held1_nxt = held1_r;
    res_valid = 1'b0;
    res       = '0;
    unique case (mode_cur)
      gdl90fr_pkg::MODE_IN_FRAME: begin
        if (is_flag) begin
          res_valid        = 1'b1;
          res.item_kind    = gdl90fr_pkg::KIND_END;
          res.frame_length = cnt_r;
          if (short_frm) begin
            res.frame_status = gdl90fr_pkg::ST_SHORT;
          end else if (crc_ok) begin
            res.frame_status = gdl90fr_pkg::ST_GOOD;
          end else begin
            res.frame_status = gdl90fr_pkg::ST_CRC_BAD;
          end
        end else if (!is_esc) begin
          take = 1'b1;
        end
      end
      gdl90fr_pkg::MODE_UNSTUFF: begin
        take = 1'b1;
      end
      default: begin
        if (is_open) begin
          cnt_nxt   = '0;
          crc_nxt   = '0;
          held0_nxt = '0;
          held1_nxt = '0;
        end
      end
    endcase
    if (take) begin
      if (ovf) begin
        res_valid        = 1'b1;
        res.item_kind    = gdl90fr_pkg::KIND_END;
        res.frame_status = gdl90fr_pkg::ST_OVERFLOW;
        res.frame_length = cnt_r;
      end else begin
        if (cnt_r >= gdl90fr_pkg::LEN_W'(2)) begin
          res_valid      = 1'b1;
          res.item_kind  = gdl90fr_pkg::KIND_BYTE;
          res.frame_byte = held0_r;
          crc_nxt        = gdl90fr_pkg::crc_step(crc_r, held0_r);
        end
        held0_nxt = held1_r;
        held1_nxt = data_b;
        cnt_nxt   = cnt_r + gdl90fr_pkg::LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= gdl90fr_pkg::MODE_IDLE;
      prev_r  <= gdl90fr_pkg::FLAG_BYTE;
      cnt_r   <= '0;
      crc_r   <= '0;
      held0_r <= '0;
      held1_r <= '0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      prev_r  <= rx_byte;
      cnt_r   <= cnt_nxt;
      crc_r   <= crc_nxt;
      held0_r <= held0_nxt;
      held1_r <= held1_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/gdl90fr_out_buf.sv
// ----------------------------------------------------------------------------
// gdl90fr_out_buf
// Result register with a skid stage; input side stalls only when both hold.
// ----------------------------------------------------------------------------
`default_nettype none

module gdl90fr_out_buf (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire gdl90fr_pkg::result_t  push_data,
  output logic                       space,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output gdl90fr_pkg::result_t       out_data
);

  logic                  main_valid_r, main_valid_nxt;
  logic                  skid_valid_r, skid_valid_nxt;
  gdl90fr_pkg::result_t  main_r, main_nxt, skid_r, skid_nxt;
  logic                  pop;

  assign pop       = main_valid_r && out_ready;
  assign space     = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || pop) begin
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = skid_r;
        skid_valid_nxt = push;
        skid_nxt       = push_data;
      end else begin
        main_valid_nxt = push;
        main_nxt       = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

>>> sv/gdl90_frame_receiver.sv
// ----------------------------------------------------------------------------
// gdl90_frame_receiver
// GDL90 deframer: flag pair open, escape unstuffing, CRC-16 check, end status.
// Each result is registered in the result register (via its skid stage when that is full) for out_ch.
// Throughput: one byte per cycle unless in_ch stalls; the parser state updates in the accept cycle.
// in_ch stalls only when the result register and its skid stage both hold.
// Reset (synchronous, rst_n low): parser idle, previous byte taken as a flag,
// min_frame_length 3, max_frame_length 512, output stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

`include "gdl90_frame_receiver_macros.svh"

module gdl90_frame_receiver #(
  parameter int unsigned MAX_FRAME_BYTES = gdl90fr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  gdl90fr_in_if.sink                              in_ch,
  gdl90fr_out_if.source                           out_ch,
  input  wire logic                               cfg_we,
  input  wire logic                               cfg_index,
  input  wire logic [gdl90fr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  gdl90fr_pkg::cfg_t     cfg_r;
  gdl90fr_pkg::result_t  res, out_data;
  logic                  res_valid, space, fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_len <= gdl90fr_pkg::MIN_LEN_W'(3);
      cfg_r.max_len <= gdl90fr_pkg::LEN_W'(512);
    end else if (cfg_we) begin
      unique case (gdl90fr_pkg::cfg_idx_t'(cfg_index))
        gdl90fr_pkg::CFG_MIN_LEN: cfg_r.min_len <= cfg_wdata[gdl90fr_pkg::MIN_LEN_W-1:0];
        gdl90fr_pkg::CFG_MAX_LEN: cfg_r.max_len <= cfg_wdata[gdl90fr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = space;
  assign fire        = in_ch.valid && space;

  gdl90fr_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .rx_byte     (in_ch.rx_byte),
    .batch_start (in_ch.batch_start),
    .cfg         (cfg_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  gdl90fr_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire && res_valid),
    .push_data (res),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_data)
  );

  assign out_ch.item_kind    = out_data.item_kind;
  assign out_ch.frame_byte   = out_data.frame_byte;
  assign out_ch.frame_status = out_data.frame_status;
  assign out_ch.frame_length = out_data.frame_length;

  `GDL90FR_ASSERT_IMPLY(a_stall_has_result, !in_ch.ready, out_ch.valid)
  `GDL90FR_ASSERT_NEXT(a_full_holds, !in_ch.ready && !out_ch.ready, !in_ch.ready)
  `GDL90FR_ASSERT_IMPLY(a_checked_len, out_ch.valid && out_ch.item_kind && (out_ch.frame_status == gdl90fr_pkg::ST_GOOD || out_ch.frame_status == gdl90fr_pkg::ST_CRC_BAD), out_ch.frame_length >= gdl90fr_pkg::ABS_MIN_LEN)
  `GDL90FR_ASSERT_IMPLY(a_byte_clean, out_ch.valid && !out_ch.item_kind, out_ch.frame_status == gdl90fr_pkg::ST_GOOD && out_ch.frame_length == '0)

endmodule

`default_nettype wire
